// ===== hw/rtl/esc_pkg.sv =====
// esc_pkg: shared types and constants of the elevation sample colorizer
// used by the channel interfaces and every module of the block
// no dependencies
package esc_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int DIFF_W      = SAMPLE_W + 1;
    localparam int NUM_W       = DIFF_W + 8;
    localparam int MAG_W       = NUM_W - 1;
    localparam int DEN_MAG_W   = DIFF_W - 1;
    localparam int QUO_W       = 9;
    localparam int COLUMN_W    = 12;
    localparam int ROW_W       = 13;
    localparam int COLOR_W     = 8;
    localparam int RASTER_W    = 13;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RASTER_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEVATION_MIN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ELEVATION_MAX = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_VALUE = 2'd3;

    localparam logic [RASTER_W-1:0]        RASTER_WIDTH_RST  = 13'd1024;
    localparam logic signed [SAMPLE_W-1:0] ELEVATION_MIN_RST = 16'sd0;
    localparam logic signed [SAMPLE_W-1:0] ELEVATION_MAX_RST = 16'sd32767;
    localparam logic signed [SAMPLE_W-1:0] SPECIAL_VALUE_RST = -16'sd500;

    localparam logic [COLOR_W-1:0] COLOR_FULL = 8'hFF;

    typedef struct packed {
        logic [RASTER_W-1:0]        raster_width;
        logic signed [SAMPLE_W-1:0] elevation_min;
        logic signed [SAMPLE_W-1:0] elevation_max;
        logic signed [SAMPLE_W-1:0] special_value;
    } t_cfg;

    // one classified item waiting for the divider
    typedef struct packed {
        logic [COLUMN_W-1:0]      column;
        logic [ROW_W-1:0]         row;
        logic                     is_water;
        logic                     neg;
        logic signed [DIFF_W-1:0] diff;
    } t_qent;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic [COLOR_W-1:0]  green;
        logic [COLOR_W-1:0]  blue;
        logic                is_water;
    } t_out;

endpackage

// ===== hw/rtl/esc_if.sv =====
// esc_if: valid/ready channel interfaces of the elevation sample colorizer
// sample input, color output and configuration write channels
// depends on esc_pkg
interface esc_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [esc_pkg::SAMPLE_W-1:0] sample;
    logic                                frame_start;

    modport source(output valid, sample, frame_start, input ready);
    modport sink(input valid, sample, frame_start, output ready);
endinterface

interface esc_out_if;
    logic                         valid;
    logic                         ready;
    logic [esc_pkg::COLUMN_W-1:0] column;
    logic [esc_pkg::ROW_W-1:0]    row;
    logic [esc_pkg::COLOR_W-1:0]  red;
    logic [esc_pkg::COLOR_W-1:0]  green;
    logic [esc_pkg::COLOR_W-1:0]  blue;
    logic                         is_water;

    modport source(output valid, column, row, red, green, blue, is_water, input ready);
    modport sink(input valid, column, row, red, green, blue, is_water, output ready);
endinterface

interface esc_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [esc_pkg::CFG_IDX_W-1:0]  index;
    logic [esc_pkg::CFG_DATA_W-1:0] data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== hw/rtl/esc_front.sv =====
// esc_front: accepts samples, tracks raster position and classifies water
// pushes one queue entry per accepted item
// depends on esc_pkg and esc_if
module esc_front #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    esc_in_if.sink           i_in,
    input  esc_pkg::t_cfg    i_cfg,
    input  logic             i_q_full,
    output logic             o_push,
    output esc_pkg::t_qent   o_push_data
);
    localparam int CW   = $clog2(MAX_COLUMNS + 1);
    localparam int RW   = $clog2(MAX_ROWS + 1);
    localparam int CMPW = (CW > esc_pkg::RASTER_W) ? CW : esc_pkg::RASTER_W;
    localparam logic [CMPW-1:0] MAXC = CMPW'(MAX_COLUMNS);
    localparam logic [RW-1:0]   MAXR = RW'(MAX_ROWS);

    logic [CW-1:0]   r_col, n_col, col_cur, col_use;
    logic [RW-1:0]   r_row, n_row, row_cur, row_use;
    logic [CMPW-1:0] width_nz, width_eff;
    logic            wrap;

    always_comb begin
        width_nz  = (i_cfg.raster_width == '0) ? CMPW'(1) : CMPW'(i_cfg.raster_width);
        width_eff = (width_nz > MAXC) ? MAXC : width_nz;
        col_cur   = i_in.frame_start ? '0 : r_col;
        row_cur   = i_in.frame_start ? '0 : r_row;
        wrap      = (col_cur == '0) || (CMPW'(col_cur) >= width_eff);
        col_use   = wrap ? '0 : col_cur;
        row_use   = (wrap && (row_cur < MAXR)) ? row_cur + RW'(1) : row_cur;
        n_col     = col_use + CW'(1);
        n_row     = row_use;
    end

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    always_comb begin
        o_push_data.column   = esc_pkg::COLUMN_W'(col_use);
        o_push_data.row      = esc_pkg::ROW_W'(row_use);
        o_push_data.neg      = i_in.sample[esc_pkg::SAMPLE_W-1];
        o_push_data.is_water = i_in.sample[esc_pkg::SAMPLE_W-1]
                               || (i_in.sample == i_cfg.special_value);
        o_push_data.diff     = esc_pkg::DIFF_W'(i_in.sample)
                               - esc_pkg::DIFF_W'(i_cfg.elevation_min);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== hw/rtl/esc_queue.sv =====
// esc_queue: short fifo of classified items between front and back
// depends on esc_pkg
module esc_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  esc_pkg::t_qent    i_push_data,
    input  logic              i_pop,
    output esc_pkg::t_qent    o_pop_data,
    output esc_pkg::t_q_stat  o_stat
);
    localparam int DEPTH = esc_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    esc_pkg::t_qent r_mem [DEPTH];
    logic [PW-1:0]  r_wr, r_rd;
    logic [NW-1:0]  r_cnt;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign o_pop_data   = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == NW'(DEPTH));
    assign o_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + NW'(1);
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - NW'(1);
            end
        end
    end

endmodule

// ===== hw/rtl/esc_back.sv =====
// esc_back: scales land samples to green with a bit-serial divider
// holds the output register of the color channel
// depends on esc_pkg and esc_if
module esc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  esc_pkg::t_cfg     i_cfg,
    input  esc_pkg::t_q_stat  i_q_stat,
    input  esc_pkg::t_qent    i_q_data,
    output logic              o_pop,
    esc_out_if.source         o_out
);
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SETUP = 4'b0010,
        S_DIV   = 4'b0100,
        S_DONE  = 4'b1000
    } t_back_state;

    localparam int STEP_W = $clog2(esc_pkg::QUO_W);

    t_back_state                          r_state;
    esc_pkg::t_qent                       r_ent;
    logic                                 r_zero;
    logic [esc_pkg::MAG_W-1:0]            r_rem, r_dsh;
    logic [esc_pkg::QUO_W-1:0]            r_quo;
    logic [STEP_W-1:0]                    r_step;
    logic                                 r_out_valid;
    esc_pkg::t_out                        r_out;

    logic signed [esc_pkg::DIFF_W-1:0]    den;
    logic signed [esc_pkg::NUM_W-1:0]     num, num_abs;
    logic signed [esc_pkg::DIFF_W-1:0]    den_abs;
    logic                                 ge;
    logic                                 out_free;
    logic [esc_pkg::COLOR_W-1:0]          green;

    // 255 * diff as a shift and subtract
    always_comb begin
        den     = esc_pkg::DIFF_W'(i_cfg.elevation_max) - esc_pkg::DIFF_W'(i_cfg.elevation_min);
        num     = (esc_pkg::NUM_W'(r_ent.diff) <<< 8) - esc_pkg::NUM_W'(r_ent.diff);
        num_abs = num[esc_pkg::NUM_W-1] ? -num : num;
        den_abs = den[esc_pkg::DIFF_W-1] ? -den : den;
        ge      = (r_rem >= r_dsh);
        out_free = !r_out_valid || o_out.ready;
        if (r_zero) begin
            green = '0;
        end else if (r_quo[esc_pkg::QUO_W-1]) begin
            green = esc_pkg::COLOR_FULL;
        end else begin
            green = r_quo[esc_pkg::COLOR_W-1:0];
        end
    end

    assign o_pop = (r_state == S_IDLE) && !i_q_stat.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_stat.empty) begin
                        r_state <= S_SETUP;
                    end
                end
                S_SETUP: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_data;
        end
        if (r_state == S_SETUP) begin
            r_zero <= r_ent.neg || (den == '0) || (num == '0)
                      || (num[esc_pkg::NUM_W-1] != den[esc_pkg::DIFF_W-1]);
            r_rem  <= num_abs[esc_pkg::MAG_W-1:0];
            r_dsh  <= {den_abs[esc_pkg::DEN_MAG_W-1:0], 8'd0};
            r_quo  <= '0;
            r_step <= STEP_W'(esc_pkg::QUO_W - 1);
        end
        if (r_state == S_DIV) begin
            r_rem  <= ge ? r_rem - r_dsh : r_rem;
            r_dsh  <= r_dsh >> 1;
            r_quo  <= {r_quo[esc_pkg::QUO_W-2:0], ge};
            r_step <= r_step - STEP_W'(1);
        end
        if ((r_state == S_DONE) && out_free) begin
            r_out.column   <= r_ent.column;
            r_out.row      <= r_ent.row;
            r_out.green    <= green;
            r_out.blue     <= r_ent.neg ? esc_pkg::COLOR_FULL : '0;
            r_out.is_water <= r_ent.is_water;
        end
    end

    assign o_out.valid    = r_out_valid;
    assign o_out.column   = r_out.column;
    assign o_out.row      = r_out.row;
    assign o_out.red      = '0;
    assign o_out.green    = r_out.green;
    assign o_out.blue     = r_out.blue;
    assign o_out.is_water = r_out.is_water;

endmodule

// ===== hw/rtl/elevation_sample_colorizer.sv =====
// elevation_sample_colorizer: top level, configuration registers and wiring
// depends on esc_pkg, esc_if, esc_front, esc_queue and esc_back
//
// usage
//   i_in carries one signed 16-bit elevation sample per item plus a
//   frame_start flag that restarts the column and row counters before it
//   o_out carries one colored item per input item, in input order
//   i_cfg writes raster_width (0), elevation_min (1), elevation_max (2) and
//   special_value (3); it is always ready and is meant to be used only
//   while the block is idle
// processing
//   an item is accepted into a two-entry queue, then the back end takes
//   it in order through pop, setup, 9 steps of a bit-serial divider for
//   255*(sample-min)/(max-min), and the load of the output register;
//   the back end pops no new item from the queue before that load is done
// reset and stalls
//   synchronous reset restores the register defaults, clears the position
//   counters, empties the queue and drops the output valid
//   while the receiver stalls the result holds, the back end waits, and
//   the front keeps taking items until the queue is full
module elevation_sample_colorizer #(
    parameter int MAX_COLUMNS = 4096,
    parameter int MAX_ROWS    = 4096
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    esc_in_if.sink     i_in,
    esc_out_if.source  o_out,
    esc_cfg_if.sink    i_cfg
);
    esc_pkg::t_cfg     r_cfg;
    esc_pkg::t_qent    push_data, pop_data;
    esc_pkg::t_q_stat  q_stat;
    logic              push, pop;

    // configuration registers; the user writes them only while idle, the block does not enforce it
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.raster_width  <= esc_pkg::RASTER_WIDTH_RST;
            r_cfg.elevation_min <= esc_pkg::ELEVATION_MIN_RST;
            r_cfg.elevation_max <= esc_pkg::ELEVATION_MAX_RST;
            r_cfg.special_value <= esc_pkg::SPECIAL_VALUE_RST;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                esc_pkg::CFG_RASTER_WIDTH: begin
                    r_cfg.raster_width <= i_cfg.data[esc_pkg::RASTER_W-1:0];
                end
                esc_pkg::CFG_ELEVATION_MIN: begin
                    r_cfg.elevation_min <= i_cfg.data;
                end
                esc_pkg::CFG_ELEVATION_MAX: begin
                    r_cfg.elevation_max <= i_cfg.data;
                end
                esc_pkg::CFG_SPECIAL_VALUE: begin
                    r_cfg.special_value <= i_cfg.data;
                end
                default: begin
                end
            endcase
        end
    end

    // front: position tracking and water classification
    esc_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg       (r_cfg),
        .i_q_full    (q_stat.full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    // queue lets the front keep accepting while the divider is busy
    esc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_pop_data  (pop_data),
        .o_stat      (q_stat)
    );

    // back: green scaling and output register
    esc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_q_stat (q_stat),
        .i_q_data (pop_data),
        .o_pop    (pop),
        .o_out    (o_out)
    );

    // queue cannot report full and empty at once
    a_queue_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // no item is taken into a full queue
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |-> !q_stat.full)
        else $error("item accepted while queue full");

    // blue items are water and carry no green
    a_blue_is_water: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && (o_out.blue != '0)) |-> (o_out.is_water && (o_out.green == '0)))
        else $error("blue item with green or without water flag");

    // rows count from one
    a_row_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.row != '0))
        else $error("result with row zero");

endmodule
